// ----- rtl/fir_filter_selectable_taps_top_assert.svh -----
// Assertion macros shared by the FIR filter RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FIR_FILTER_SELECTABLE_TAPS_TOP_ASSERT_SVH
`define FIR_FILTER_SELECTABLE_TAPS_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fst assertion failed");

// A condition that must be followed in the next cycle by a consequence.
`define FST_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("fst assertion failed");

`endif

// ----- rtl/fst_pkg.sv -----
// Shared constants, types and helper functions for the selectable-length FIR filter.
// Used by the channel interfaces and by every RTL module; depends on nothing.
package fst_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_TAPS    = 64;
  localparam int NUM_SETS    = 3;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // Filter lengths of the three coefficient sets.
  localparam int SHORT_TAPS  = 16;
  localparam int MEDIUM_TAPS = 32;
  localparam int LONG_TAPS   = 64;

  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int COEF_DEPTH  = NUM_SETS * MAX_TAPS;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + TAP_CNT_W;

  // Fixed field widths of the input beat.
  localparam int CMD_W       = 2;
  localparam int SEL_W       = 2;
  localparam int IDX_FIELD_W = 6;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_FILL   = 2'd2
  } cmd_t;

  typedef enum logic [SEL_W-1:0] {
    SET_SHORT  = 2'd0,
    SET_MEDIUM = 2'd1,
    SET_LONG   = 2'd2
  } coef_set_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic issue_en;
    logic issue_last;
  } mac_ctrl_t;

  // Number of taps of a coefficient set, never more than the history holds.
  function automatic logic [TAP_CNT_W-1:0] set_length(input logic [SEL_W-1:0] set);
    int len;
    case (set)
      SET_SHORT:  len = SHORT_TAPS;
      SET_MEDIUM: len = MEDIUM_TAPS;
      default:    len = LONG_TAPS;
    endcase
    if (len > MAX_TAPS) len = MAX_TAPS;
    return TAP_CNT_W'(len);
  endfunction

endpackage

// ----- rtl/fst_chan_if.sv -----
// Valid/ready channel interfaces for the FIR filter: input beats and result beats.
// Depends on fst_pkg for field widths.
interface fst_in_if;
  logic                              valid;
  logic                              ready;
  logic [fst_pkg::CMD_W-1:0]         cmd;
  fst_pkg::sample_t                  sample;
  logic [fst_pkg::SEL_W-1:0]         coef_set;
  logic [fst_pkg::IDX_FIELD_W-1:0]   coef_index;
  fst_pkg::sample_t                  coef_value;

  modport source (output valid, cmd, sample, coef_set, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, cmd, sample, coef_set, coef_index, coef_value,
                  output ready);
endinterface

interface fst_out_if;
  logic             valid;
  logic             ready;
  fst_pkg::sample_t filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

// ----- rtl/fst_hist.sv -----
// Sample history: a circular buffer in a one-port-write, one-port-read RAM.
// Per-entry valid bits give the whole-buffer fill and clear without writing the RAM.
// Depends on fst_pkg and the assertion header.
`include "fir_filter_selectable_taps_top_assert.svh"

module fst_hist (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push_en,
  input  fst_pkg::sample_t                push_data,
  input  logic                            clear_en,
  input  fst_pkg::sample_t                clear_data,
  input  logic                            rd_en,
  input  logic [fst_pkg::TAP_IDX_W-1:0]   rd_tap,
  output fst_pkg::sample_t                rd_data
);

  fst_pkg::sample_t                    mem [fst_pkg::MAX_TAPS];
  logic [fst_pkg::MAX_TAPS-1:0]        valid;
  logic [fst_pkg::TAP_IDX_W-1:0]       ptr;
  logic [fst_pkg::TAP_IDX_W-1:0]       ptr_next;
  logic [fst_pkg::TAP_IDX_W:0]         addr_sum;
  logic [fst_pkg::TAP_IDX_W-1:0]       rd_addr;
  fst_pkg::sample_t                    fill_val;
  fst_pkg::sample_t                    mem_q;
  logic                                vld_q;

  // The newest sample sits at ptr; a push steps ptr back by one with wrap.
  always_comb begin
    if (ptr == '0) begin
      ptr_next = fst_pkg::TAP_IDX_W'(fst_pkg::MAX_TAPS - 1);
    end else begin
      ptr_next = ptr - 1'b1;
    end
  end

  // Tap i of the history lives at ptr + i, modulo the buffer depth.
  always_comb begin
    addr_sum = {1'b0, ptr} + {1'b0, rd_tap};
    if (addr_sum >= (fst_pkg::TAP_IDX_W + 1)'(fst_pkg::MAX_TAPS)) begin
      addr_sum = addr_sum - (fst_pkg::TAP_IDX_W + 1)'(fst_pkg::MAX_TAPS);
    end
    rd_addr = addr_sum[fst_pkg::TAP_IDX_W-1:0];
  end

  // Pointer, valid bits and the value that unwritten entries read as.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      valid    <= '0;
      fill_val <= '0;
    end else if (clear_en) begin
      valid    <= '0;
      fill_val <= clear_data;
    end else if (push_en) begin
      ptr             <= ptr_next;
      valid[ptr_next] <= 1'b1;
    end
  end

  // History RAM with a registered read port.
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[ptr_next] <= push_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : fill_val;

  // A push only happens when the sequencer is idle, so it never meets a read.
  `FST_ASSERT(a_hist_no_push_during_read, !(push_en && rd_en))

endmodule

// ----- rtl/fst_coef.sv -----
// Coefficient store: the three tap-weight sets in one RAM, set s at s * MAX_TAPS.
// Valid bits make never-loaded weights read as zero from reset.
// Depends on fst_pkg.
module fst_coef (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [fst_pkg::SEL_W-1:0]         wr_set,
  input  logic [fst_pkg::IDX_FIELD_W-1:0]   wr_idx,
  input  fst_pkg::sample_t                  wr_data,
  input  logic                              rd_en,
  input  fst_pkg::coef_set_t                rd_set,
  input  logic [fst_pkg::TAP_IDX_W-1:0]     rd_tap,
  output fst_pkg::sample_t                  rd_data
);

  fst_pkg::sample_t                 mem [fst_pkg::COEF_DEPTH];
  logic [fst_pkg::COEF_DEPTH-1:0]   valid;
  logic                             wr_ok;
  logic [fst_pkg::COEF_AW-1:0]      wr_addr;
  logic [fst_pkg::COEF_AW-1:0]      rd_addr;
  fst_pkg::sample_t                 mem_q;
  logic                             vld_q;

  // Loads to an unknown set or past the set's length are dropped.
  always_comb begin
    wr_ok   = wr_en && (wr_set <= fst_pkg::SET_LONG) &&
              (int'(wr_idx) < int'(fst_pkg::set_length(wr_set)));
    wr_addr = fst_pkg::COEF_AW'(wr_set) * fst_pkg::COEF_AW'(fst_pkg::MAX_TAPS) +
              fst_pkg::COEF_AW'(wr_idx);
    rd_addr = fst_pkg::COEF_AW'(rd_set) * fst_pkg::COEF_AW'(fst_pkg::MAX_TAPS) +
              fst_pkg::COEF_AW'(rd_tap);
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Weight RAM with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// ----- rtl/fst_mac.sv -----
// Shared multiply-accumulate unit: one tap per cycle, then round half up and saturate.
// Stages: RAM read, product register, accumulator. Depends on fst_pkg and the
// assertion header.
`include "fir_filter_selectable_taps_top_assert.svh"

module fst_mac (
  input  logic                clk,
  input  logic                rst,
  input  fst_pkg::mac_ctrl_t  ctrl,
  input  fst_pkg::sample_t    hist_data,
  input  fst_pkg::sample_t    coef_data,
  output logic                acc_ready,
  output fst_pkg::sample_t    result
);

  localparam logic signed [fst_pkg::ACC_W:0] SAT_HI =
    (fst_pkg::ACC_W + 1)'(2 ** (fst_pkg::SAMPLE_BITS - 1) - 1);
  localparam logic signed [fst_pkg::ACC_W:0] SAT_LO =
    (fst_pkg::ACC_W + 1)'(-(2 ** (fst_pkg::SAMPLE_BITS - 1)));
  localparam logic signed [fst_pkg::ACC_W:0] HALF_LSB =
    (fst_pkg::ACC_W + 1)'(2 ** (fst_pkg::FRAC_BITS - 1));

  logic                                 v1;
  logic                                 last1;
  logic                                 v2;
  logic                                 last2;
  logic signed [fst_pkg::PROD_W-1:0]    prod;
  logic signed [fst_pkg::ACC_W-1:0]     acc;
  logic signed [fst_pkg::ACC_W:0]       rounded;
  logic signed [fst_pkg::ACC_W:0]       shifted;

  // Valid and last flags follow the data through the read and product stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      last1     <= 1'b0;
      v2        <= 1'b0;
      last2     <= 1'b0;
      acc_ready <= 1'b0;
    end else begin
      v1    <= ctrl.issue_en;
      last1 <= ctrl.issue_last;
      v2    <= v1;
      last2 <= v1 && last1;
      if (ctrl.start) begin
        acc_ready <= 1'b0;
      end else if (v2 && last2) begin
        acc_ready <= 1'b1;
      end
    end
  end

  // Product register, then the wide accumulator.
  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= hist_data * coef_data;
    end
    if (ctrl.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + fst_pkg::ACC_W'(prod);
    end
  end

  // Round half up to Q1.15, then clamp to the sample range.
  always_comb begin
    rounded = (fst_pkg::ACC_W + 1)'(acc) + HALF_LSB;
    shifted = rounded >>> fst_pkg::FRAC_BITS;
    if (shifted > SAT_HI) begin
      result = SAT_HI[fst_pkg::SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      result = SAT_LO[fst_pkg::SAMPLE_BITS-1:0];
    end else begin
      result = shifted[fst_pkg::SAMPLE_BITS-1:0];
    end
  end

  // The last tap leaving the product stage completes the sum.
  `FST_ASSERT_NEXT(a_mac_last_sets_ready, v2 && last2 && !ctrl.start, acc_ready)
  // A finished sum is only withdrawn by the start of the next sample.
  `FST_ASSERT(a_mac_ready_drop, $fell(acc_ready) |-> $past(ctrl.start))

endmodule

// ----- rtl/fir_filter_selectable_taps_top.sv -----
// Top level of the selectable-length FIR filter: sequencer, history and weight
// memories, shared MAC and result register. Depends on fst_pkg, fst_chan_if,
// fst_hist, fst_coef, fst_mac and the assertion header.
//
//   Channel   Dir  Handshake      Beat contents
//   samples   in   valid/ready    cmd, sample, coef_set, coef_index, coef_value
//   results   out  valid/ready    filtered
//   cfg       in   cfg_we         cfg_wdata = tap_mode
//
// A sample beat keeps the block busy: the sequencer issues every tap of the
// active length in the run state, then waits in the drain state until the sum
// is loaded into the output register, and the next beat is accepted back in idle.
// The pace is set by the single MAC, which reads one tap a cycle from the
// history and weight RAMs. Load, fill and unknown beats leave the sequencer idle.
// Reset needs no clearing pass: valid bits make both memories read as zero.
// A result waiting in the output register stalls only the next sample's final step.
`include "fir_filter_selectable_taps_top_assert.svh"

module fir_filter_selectable_taps_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fst_pkg::SEL_W-1:0]  cfg_wdata,
  fst_in_if.sink                     samples,
  fst_out_if.source                  results
);

  fst_pkg::state_t                    state;
  fst_pkg::state_t                    state_next;
  logic [fst_pkg::SEL_W-1:0]          tap_mode;
  fst_pkg::coef_set_t                 mode_set;
  fst_pkg::coef_set_t                 run_set;
  logic [fst_pkg::TAP_CNT_W-1:0]      tap_len;
  logic [fst_pkg::TAP_CNT_W-1:0]      tap_cnt;
  logic                               accept;
  logic                               is_filter;
  logic                               is_load;
  logic                               is_fill;
  logic                               out_load;
  logic                               out_valid;
  fst_pkg::sample_t                   out_data;
  fst_pkg::mac_ctrl_t                 mac_ctrl;
  fst_pkg::sample_t                   hist_data;
  fst_pkg::sample_t                   coef_data;
  logic                               acc_ready;
  fst_pkg::sample_t                   mac_result;
  logic                               hist_clear;
  fst_pkg::sample_t                   hist_clear_data;

  // Beat decode. Mode three behaves as the long set.
  always_comb begin
    accept    = samples.valid && samples.ready;
    is_filter = samples.cmd == fst_pkg::CMD_FILTER;
    is_load   = samples.cmd == fst_pkg::CMD_LOAD;
    is_fill   = samples.cmd == fst_pkg::CMD_FILL;
    mode_set  = (tap_mode > fst_pkg::SET_LONG) ? fst_pkg::SET_LONG :
                fst_pkg::coef_set_t'(tap_mode);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      fst_pkg::ST_IDLE: begin
        if (accept && is_filter) state_next = fst_pkg::ST_RUN;
      end
      fst_pkg::ST_RUN: begin
        if (mac_ctrl.issue_last) state_next = fst_pkg::ST_DRAIN;
      end
      fst_pkg::ST_DRAIN: begin
        if (out_load) state_next = fst_pkg::ST_IDLE;
      end
      default: state_next = fst_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    samples.ready       = state == fst_pkg::ST_IDLE;
    mac_ctrl.start      = accept && is_filter;
    mac_ctrl.issue_en   = state == fst_pkg::ST_RUN;
    mac_ctrl.issue_last = (state == fst_pkg::ST_RUN) &&
                          (tap_cnt == tap_len - 1'b1);
    out_load            = (state == fst_pkg::ST_DRAIN) && acc_ready &&
                          (!out_valid || results.ready);
  end

  // Control registers: state, tap mode, tap counter, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fst_pkg::ST_IDLE;
      tap_mode  <= '0;
      tap_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tap_mode <= cfg_wdata;
      end
      if (mac_ctrl.start) begin
        tap_cnt <= '0;
      end else if (mac_ctrl.issue_en) begin
        tap_cnt <= tap_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-sample set and length, and the result payload.
  always_ff @(posedge clk) begin
    if (mac_ctrl.start) begin
      run_set <= mode_set;
      tap_len <= fst_pkg::set_length(mode_set);
    end
    if (out_load) begin
      out_data <= mac_result;
    end
  end

  assign results.valid    = out_valid;
  assign results.filtered = out_data;

  // A tap mode write clears the history to zero; a fill beat sets it to the sample.
  always_comb begin
    hist_clear      = cfg_we || (accept && is_fill);
    hist_clear_data = cfg_we ? '0 : samples.sample;
  end

  fst_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .push_en    (mac_ctrl.start),
    .push_data  (samples.sample),
    .clear_en   (hist_clear),
    .clear_data (hist_clear_data),
    .rd_en      (mac_ctrl.issue_en),
    .rd_tap     (tap_cnt[fst_pkg::TAP_IDX_W-1:0]),
    .rd_data    (hist_data)
  );

  fst_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && is_load),
    .wr_set  (samples.coef_set),
    .wr_idx  (samples.coef_index),
    .wr_data (samples.coef_value),
    .rd_en   (mac_ctrl.issue_en),
    .rd_set  (run_set),
    .rd_tap  (tap_cnt[fst_pkg::TAP_IDX_W-1:0]),
    .rd_data (coef_data)
  );

  fst_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .hist_data (hist_data),
    .coef_data (coef_data),
    .acc_ready (acc_ready),
    .result    (mac_result)
  );

  // A new result never overwrites one that has not been taken.
  `FST_ASSERT(a_top_no_overwrite, out_load |-> (!out_valid || results.ready))
  // The tap counter never runs past the active filter length.
  `FST_ASSERT(a_top_issue_range, mac_ctrl.issue_en |-> (tap_cnt < tap_len))

endmodule
